/* hw/rtl/nqls_pkg.sv */
package nqls_pkg;

  // Widths fixed by the register and field definitions.
  localparam int unsigned CNT_W       = 6;   // sizes, counts, depth, tries
  localparam int unsigned ROW_W       = 6;   // internal row value
  localparam int unsigned IN_ROW_W    = 5;   // start_row field
  localparam int unsigned OUT_ROW_W   = 5;   // row field
  localparam int unsigned LIM_W       = 16;  // step_limit and step counter
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam int unsigned MAX_SIZE_DEF = 32;

  localparam logic [CNT_W-1:0] BOARD_SIZE_RST = CNT_W'(8);
  localparam logic [LIM_W-1:0] STEP_LIMIT_RST = LIM_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOARD_SIZE = 1'b0,
    REG_STEP_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ENTER   = 9'b000000010,
    S_ENTER_W = 9'b000000100,
    S_CHK     = 9'b000001000,
    S_CMP     = 9'b000010000,
    S_ADV     = 9'b000100000,
    S_BACK    = 9'b001000000,
    S_OUT_RD  = 9'b010000000,
    S_OUT_W   = 9'b100000000
  } state_e;

  // A stored row at or above the board size reads as row zero.
  function automatic logic [ROW_W-1:0] fix_row(input logic [ROW_W-1:0] v,
                                               input logic [CNT_W-1:0] sz);
    logic [ROW_W-1:0] r;
    r = (v >= sz) ? '0 : v;
    return r;
  endfunction

endpackage

/* hw/rtl/nqls_ram.sv */
module nqls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]              wdata_i,
  input  logic                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/n_queens_limited_search.sv */
// Bounded depth-first N-queens search.
//
// Input stream (s_axis_*): one transaction per column carries that column's
// starting row, in column order, accepted one per cycle while the block is
// loading. The transaction that completes board_size columns starts the
// search; s_axis_tready stays low until the search and all but the last
// result are done.
// Output stream (m_axis_*): one transaction per column with the final row in
// tdata, the found flag in tuser and tlast on the final column.
// Configuration: cfg_we_i writes board_size (index 0) or step_limit (index 1)
// at a rising edge; write only while the block is idle.
// One shared clash checker reads one earlier column at a time in S_CHK
// and S_CMP; entering a column passes S_ENTER and S_ENTER_W, a row advance
// S_ADV and a backtrack S_BACK. Advances are bounded by step_limit and by
// board_size tries per column. Each result then passes through the memory
// read port and the output register.
// Reset clears the control state, the load count and the output valid and
// restores board_size to 8 and step_limit to 64; the row memories need no
// clearing. A stalled receiver holds the output register and the block waits;
// loading of the next board already runs while the last result waits.
module n_queens_limited_search #(
  parameter int unsigned MAX_SIZE = nqls_pkg::MAX_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input: [4:0] start_row, [7:5] zero.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [nqls_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Output: [4:0] row, [7:5] zero.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [nqls_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Output flag: [0] found.
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [nqls_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [nqls_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CW    = nqls_pkg::CNT_W;
  localparam int unsigned RW    = nqls_pkg::ROW_W;
  localparam int unsigned LW    = nqls_pkg::LIM_W;

  nqls_pkg::state_e state_q, state_d;

  logic [CW-1:0]    bs_q;
  logic [LW-1:0]    sl_q;
  logic [CW-1:0]    lc_q, lc_d;
  logic [IDX_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]    d_q, d_d;
  logic [CW-1:0]    x_q, x_d;
  logic [CW-1:0]    k_q, k_d;
  logic [LW-1:0]    step_q, step_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    tries_q, tries_d;
  logic             found_q, found_d;

  logic                 out_v_q;
  logic [nqls_pkg::OUT_ROW_W-1:0] out_row_q;
  logic                 out_found_q;
  logic                 out_last_q;
  logic                 out_load;

  logic [CW-1:0]    size;
  logic [CW-1:0]    lc_inc;
  logic [IDX_W-1:0] wr_ptr_inc;
  logic [CW-1:0]    dm1;
  logic [CW-1:0]    col_gap;
  logic [RW-1:0]    prev_row;
  logic             clash;
  logic             step_ok;
  logic [CW-1:0]    tries_dec;
  logic [RW-1:0]    row_nxt;
  logic [CW-1:0]    k_inc;

  logic             pos_we, pos_re;
  logic [IDX_W-1:0] pos_waddr, pos_raddr;
  logic [RW-1:0]    pos_wdata, pos_rdata;
  logic             tries_we, tries_re;
  logic [CW-1:0]    tries_rdata;

  // Effective board size: zero counts as one, large values clamp to the
  // memory depth.
  always_comb begin
    if (bs_q == '0) begin
      size = CW'(1);
    end else if ({1'b0, bs_q} > (CW + 1)'(MAX_SIZE)) begin
      size = CW'(MAX_SIZE);
    end else begin
      size = bs_q;
    end
  end

  assign lc_inc     = lc_q + CW'(1);
  assign wr_ptr_inc = (wr_ptr_q == IDX_W'(MAX_SIZE - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
  assign dm1        = d_q - CW'(1);
  assign k_inc      = k_q + CW'(1);

  // Shared clash test of the current row against one earlier column.
  assign col_gap  = d_q - x_q;
  assign prev_row = nqls_pkg::fix_row(pos_rdata, size);
  assign clash    = (prev_row == row_q) ||
                    ({1'b0, prev_row} == {1'b0, row_q} + {1'b0, col_gap}) ||
                    ({1'b0, row_q} == {1'b0, prev_row} + {1'b0, col_gap});

  assign step_ok   = ({1'b0, step_q} + (LW + 1)'(1)) < {1'b0, sl_q};
  assign tries_dec = tries_q - CW'(1);
  assign row_nxt   = ({1'b0, row_q} + (RW + 1)'(1) == {1'b0, size}) ? '0 : row_q + RW'(1);

  always_comb begin
    state_d   = state_q;
    lc_d      = lc_q;
    wr_ptr_d  = wr_ptr_q;
    d_d       = d_q;
    x_d       = x_q;
    k_d       = k_q;
    step_d    = step_q;
    row_d     = row_q;
    tries_d   = tries_q;
    found_d   = found_q;
    out_load  = 1'b0;
    pos_we    = 1'b0;
    pos_waddr = d_q[IDX_W-1:0];
    pos_wdata = row_q;
    pos_re    = 1'b0;
    pos_raddr = d_q[IDX_W-1:0];
    tries_we  = 1'b0;
    tries_re  = 1'b0;

    case (state_q)
      nqls_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          pos_we    = 1'b1;
          pos_waddr = wr_ptr_q;
          pos_wdata = RW'(s_axis_tdata[nqls_pkg::IN_ROW_W-1:0]);
          if (lc_inc >= size) begin
            lc_d     = '0;
            wr_ptr_d = '0;
            d_d      = '0;
            step_d   = '0;
            state_d  = nqls_pkg::S_ENTER;
          end else begin
            lc_d     = lc_inc;
            wr_ptr_d = wr_ptr_inc;
          end
        end
      end
      nqls_pkg::S_ENTER: begin
        if (d_q >= size) begin
          found_d = 1'b1;
          k_d     = '0;
          state_d = nqls_pkg::S_OUT_RD;
        end else begin
          pos_re  = 1'b1;
          tries_d = size;
          state_d = nqls_pkg::S_ENTER_W;
        end
      end
      nqls_pkg::S_ENTER_W: begin
        row_d   = nqls_pkg::fix_row(pos_rdata, size);
        x_d     = '0;
        state_d = nqls_pkg::S_CHK;
      end
      nqls_pkg::S_CHK: begin
        if (x_q == d_q) begin
          // No clash with any earlier column: keep this row and go deeper.
          pos_we   = 1'b1;
          tries_we = 1'b1;
          d_d      = d_q + CW'(1);
          state_d  = nqls_pkg::S_ENTER;
        end else begin
          pos_re    = 1'b1;
          pos_raddr = x_q[IDX_W-1:0];
          state_d   = nqls_pkg::S_CMP;
        end
      end
      nqls_pkg::S_CMP: begin
        if (clash) begin
          state_d = nqls_pkg::S_ADV;
        end else begin
          x_d     = x_q + CW'(1);
          state_d = nqls_pkg::S_CHK;
        end
      end
      nqls_pkg::S_ADV: begin
        row_d   = row_nxt;
        tries_d = tries_dec;
        if (tries_dec != '0 && step_ok) begin
          step_d  = step_q + LW'(1);
          x_d     = '0;
          state_d = nqls_pkg::S_CHK;
        end else begin
          // Column gives up: store its advanced row, then fail or backtrack.
          pos_we    = 1'b1;
          pos_wdata = row_nxt;
          if (d_q == '0) begin
            found_d = 1'b0;
            k_d     = '0;
            state_d = nqls_pkg::S_OUT_RD;
          end else begin
            d_d       = dm1;
            pos_re    = 1'b1;
            pos_raddr = dm1[IDX_W-1:0];
            tries_re  = 1'b1;
            state_d   = nqls_pkg::S_BACK;
          end
        end
      end
      nqls_pkg::S_BACK: begin
        row_d   = pos_rdata;
        tries_d = tries_rdata;
        state_d = nqls_pkg::S_ADV;
      end
      nqls_pkg::S_OUT_RD: begin
        if (!out_v_q || m_axis_tready) begin
          pos_re    = 1'b1;
          pos_raddr = k_q[IDX_W-1:0];
          state_d   = nqls_pkg::S_OUT_W;
        end
      end
      nqls_pkg::S_OUT_W: begin
        out_load = 1'b1;
        k_d      = k_inc;
        state_d  = (k_inc == size) ? nqls_pkg::S_IDLE : nqls_pkg::S_OUT_RD;
      end
      default: begin
        state_d = nqls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nqls_pkg::S_IDLE;
      bs_q     <= nqls_pkg::BOARD_SIZE_RST;
      sl_q     <= nqls_pkg::STEP_LIMIT_RST;
      lc_q     <= '0;
      wr_ptr_q <= '0;
      d_q      <= '0;
      x_q      <= '0;
      k_q      <= '0;
      step_q   <= '0;
      found_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      lc_q     <= lc_d;
      wr_ptr_q <= wr_ptr_d;
      d_q      <= d_d;
      x_q      <= x_d;
      k_q      <= k_d;
      step_q   <= step_d;
      found_q  <= found_d;
      if (cfg_we_i) begin
        case (nqls_pkg::reg_idx_e'(cfg_idx_i))
          nqls_pkg::REG_BOARD_SIZE: bs_q <= cfg_data_i[CW-1:0];
          nqls_pkg::REG_STEP_LIMIT: sl_q <= cfg_data_i[LW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Working row, tries and output payload carry no reset.
  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    tries_q <= tries_d;
    if (out_load) begin
      out_row_q   <= prev_row[nqls_pkg::OUT_ROW_W-1:0];
      out_found_q <= found_q;
      out_last_q  <= (k_inc == size);
    end
  end

  nqls_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_SIZE)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  nqls_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_SIZE)
  ) u_tries_ram (
    .clk_i   (clk_i),
    .we_i    (tries_we),
    .waddr_i (d_q[IDX_W-1:0]),
    .wdata_i (tries_q),
    .re_i    (tries_re),
    .raddr_i (dm1[IDX_W-1:0]),
    .rdata_o (tries_rdata)
  );

  assign s_axis_tready = (state_q == nqls_pkg::S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(nqls_pkg::OUT_TDATA_W - nqls_pkg::OUT_ROW_W)'(0), out_row_q};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* hw/rtl/nqls_checker.sv */
module nqls_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [nqls_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast
);

  logic in_frame_q;
  logic frame_found_q;

  // Remember the found flag of the frame in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      frame_found_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      in_frame_q    <= !m_axis_tlast;
      frame_found_q <= m_axis_tuser;
    end
  end

  a_found_per_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && in_frame_q) |-> (m_axis_tuser == frame_found_q))
    else $error("found flag changed within a result frame");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[nqls_pkg::OUT_TDATA_W-1:nqls_pkg::OUT_ROW_W] == '0))
    else $error("output padding bits not zero");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("output payload changed while stalled");

endmodule

bind n_queens_limited_search nqls_checker u_nqls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* sim/n_queens_limited_search_tb.sv */
module n_queens_limited_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The board size is capped by the row memory depth of the block.
  localparam int unsigned BOARD_MAX       = nqls_pkg::MAX_SIZE_DEF;
  // Longest stretch without any transaction before the run is declared hung.
  // The slowest search used here (eight columns with a budget of 3000
  // advances, each advance and the column entry after it followed by clash
  // scans over the earlier columns) stays well below it.
  localparam int unsigned WATCHDOG_CYCLES = 1000000;
  // Cycles allowed for the control to fall back to idle after the final
  // column result has been taken, before any register write.
  localparam int unsigned SETTLE_CYCLES   = 16;
  // Length of the long output hold-off used to back the block up.
  localparam int unsigned HOLDOFF_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS    = 400;

  // One column result as it should appear on the output stream.
  typedef struct packed {
    logic [nqls_pkg::OUT_TDATA_W-1:0] tdata;
    logic                             found;
    logic                             last;
  } placement_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // Input tdata: [4:0] start_row, [7:5] zero.
  logic [nqls_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // Output tdata: [4:0] row, [7:5] zero.
  logic [nqls_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  // Output tuser: [0] found.
  logic                             m_axis_tuser;
  logic                             m_axis_tlast;
  logic                             cfg_we_i   = 1'b0;
  logic [nqls_pkg::CFG_IDX_W-1:0]   cfg_idx_i  = '0;
  logic [nqls_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;

  n_queens_limited_search #(
    .MAX_SIZE(BOARD_MAX)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Search predictor. It mirrors the register file, the row memory and the
  // load counter of the block, and runs the whole bounded depth-first search
  // in zero time when the transaction that completes a board is accepted.
  // ---------------------------------------------------------------------------
  logic [5:0]     size_cfg  = nqls_pkg::BOARD_SIZE_RST;
  logic [15:0]    limit_cfg = nqls_pkg::STEP_LIMIT_RST;
  logic [4:0]     board_rows [BOARD_MAX];
  int unsigned    row_tries  [BOARD_MAX];
  int unsigned    rows_loaded = 0;
  placement_t     placement_q [$];

  int unsigned    items_sent      = 0;
  int unsigned    searches_run    = 0;
  int unsigned    searches_solved = 0;
  int unsigned    settings_used   = 0;
  int unsigned    results_checked = 0;
  int unsigned    mismatch_count  = 0;

  // A size of zero behaves as one, and anything past the memory depth as the
  // full depth.
  function automatic int unsigned effective_size();
    int unsigned s;
    s = size_cfg;
    if (s == 0) s = 1;
    if (s > BOARD_MAX) s = BOARD_MAX;
    return s;
  endfunction

  // True when the queen of column col shares no row and no diagonal with any
  // queen to its left.
  function automatic bit row_is_safe(int unsigned col);
    int delta;
    int span;
    for (int unsigned x = 0; x < col; x++) begin
      delta = int'(board_rows[x]) - int'(board_rows[col]);
      span  = int'(col - x);
      if (delta == 0 || delta == span || delta == -span) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Depth-first search over columns 0..n-1. Each column gets n tries in a
  // cyclic order starting from its loaded row; every advance that may try
  // again spends one step of the budget, and an exhausted budget makes the
  // column give up, which unwinds the whole search.
  function automatic bit search_placement(int unsigned n);
    int unsigned col;
    int unsigned steps;
    bit          entering;
    // Rows that do not fit on the board start from row zero.
    for (int unsigned c = 0; c < n; c++)
      if (board_rows[c] >= n) board_rows[c] = '0;
    col      = 0;
    steps    = 0;
    entering = 1'b1;
    while (1'b1) begin
      if (entering) begin
        if (col >= n) return 1'b1;
        row_tries[col] = n;
        if (row_is_safe(col)) begin
          col++;
          continue;
        end
      end
      board_rows[col] = (board_rows[col] + 1 == n) ? 5'd0 : 5'(board_rows[col] + 1);
      row_tries[col]--;
      if (row_tries[col] != 0 && steps + 1 < limit_cfg) begin
        steps++;
        entering = row_is_safe(col);
        if (entering) col++;
        continue;
      end
      if (col == 0) return 1'b0;
      entering = 1'b0;
      col--;
    end
    return 1'b0;
  endfunction

  // Called once per accepted input transaction.
  function automatic void predict_placements(logic [4:0] start_row);
    int unsigned n;
    bit          found;
    n = effective_size();
    board_rows[rows_loaded % BOARD_MAX] = start_row;
    rows_loaded = (rows_loaded + 1) % 64;
    if (rows_loaded < n) return;
    found = search_placement(n);
    searches_run++;
    if (found) searches_solved++;
    for (int unsigned c = 0; c < n; c++)
      placement_q.push_back(placement_t'{tdata: nqls_pkg::OUT_TDATA_W'(board_rows[c]),
                                         found: found, last: (c + 1 == n)});
    rows_loaded = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. The valid stays high from one transaction to the next unless
  // an idle gap is drawn, so back-to-back rows never toggle it within a step.
  // ---------------------------------------------------------------------------
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  task automatic send_row(input logic [4:0] start_row);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= nqls_pkg::IN_TDATA_W'(start_row);
    do @(posedge clk_i); while (!s_axis_tready);
    predict_placements(start_row);
    items_sent++;
  endtask

  // Mostly rows that fit the board, with some that need the wrap to row zero.
  function automatic logic [4:0] pick_start_row(int unsigned n);
    if ($urandom_range(0, 99) < 80) return 5'($urandom_range(0, n - 1));
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic send_board();
    int unsigned n;
    n = effective_size();
    for (int unsigned c = 0; c < n; c++) send_row(pick_start_row(n));
  endtask

  // Stops offering rows, waits until every predicted result has come out and
  // then gives the control time to return to idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called while the block is idle, so the predictor can take the new
  // value at once.
  task automatic write_reg(input nqls_pkg::reg_idx_e idx,
                           input logic [nqls_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == nqls_pkg::REG_BOARD_SIZE) begin
      size_cfg = value[5:0];
    end else begin
      limit_cfg = value;
    end
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side. The ready is redrawn every cycle from the stall percentage,
  // except while a hold-off is counting down. A hold-off is requested by
  // bumping holdoff_requests; this process does its own counting.
  // ---------------------------------------------------------------------------
  int unsigned holdoff_requests = 0;
  int unsigned holdoff_served   = 0;
  int unsigned holdoff_left     = 0;

  always @(posedge clk_i) begin
    if (holdoff_served != holdoff_requests) begin
      holdoff_served = holdoff_requests;
      holdoff_left   = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Every output transaction is matched against the oldest predicted column.
  placement_t expected_placement;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (placement_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, got row %0d found %0b last %0b",
                 $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        expected_placement = placement_q.pop_front();
        results_checked++;
        if (m_axis_tdata !== expected_placement.tdata) begin
          mismatch_count++;
          $display("%0t: row mismatch: expected %0d, got %0d",
                   $realtime, expected_placement.tdata, m_axis_tdata);
        end
        if (m_axis_tuser !== expected_placement.found) begin
          mismatch_count++;
          $display("%0t: found mismatch: expected %0b, got %0b",
                   $realtime, expected_placement.found, m_axis_tuser);
        end
        if (m_axis_tlast !== expected_placement.last) begin
          mismatch_count++;
          $display("%0t: last mismatch: expected %0b, got %0b",
                   $realtime, expected_placement.last, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog: a search that never finishes or a stream that locks up shows
  // as a long run of cycles without any transaction on either side.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("%0t: no transaction for %0d cycles, %0d results still outstanding",
               $realtime, WATCHDOG_CYCLES, placement_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases without any idling: reset settings, rows off the board,
  // the smallest boards, a zero budget, the largest budget on a board with
  // no solution, and a size lowered while a board is partly loaded.
  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    // Reset settings: eight columns, budget of 64. Every row is off the
    // board and restarts from row zero.
    repeat (8) send_row(5'd31);
    drain_results();
    // One column with no budget at all.
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd1);
    write_reg(nqls_pkg::REG_STEP_LIMIT, 16'd0);
    send_row(5'd0);
    drain_results();
    // A size of zero behaves as a single column; row 31 wraps to zero.
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd0);
    send_row(5'd31);
    drain_results();
    // Zero budget on clashing rows: the first clash gives up and unwinds the search.
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd4);
    send_row(5'd1);
    send_row(5'd1);
    send_row(5'd2);
    send_row(5'd3);
    drain_results();
    // Full budget on three columns, which have no placement at all.
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd3);
    write_reg(nqls_pkg::REG_STEP_LIMIT, 16'hFFFF);
    send_row(5'd0);
    send_row(5'd2);
    send_row(5'd1);
    drain_results();
    // Five rows into an eight-column board, then the size drops to three:
    // the next row lands in column five and the first three columns are
    // searched.
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd8);
    write_reg(nqls_pkg::REG_STEP_LIMIT, 16'd64);
    repeat (5) send_row(pick_start_row(8));
    drain_results();
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd3);
    send_row(pick_start_row(8));
    drain_results();
  endtask

  // The receiver holds off for a long stretch while rows keep coming, so the
  // block parks on its first result and stops taking input.
  task automatic test_output_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd4);
    write_reg(nqls_pkg::REG_STEP_LIMIT, 16'd40);
    holdoff_requests++;
    repeat (4) send_board();
    drain_results();
  endtask

  // The full memory depth, once through a size above the cap and once
  // directly, with a small budget to keep the search short.
  task automatic test_largest_board();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd63);
    write_reg(nqls_pkg::REG_STEP_LIMIT, 16'd250);
    send_board();
    drain_results();
    write_reg(nqls_pkg::REG_BOARD_SIZE, 16'd32);
    write_reg(nqls_pkg::REG_STEP_LIMIT, 16'd120);
    send_board();
    drain_results();
  endtask

  // Draws a board size and a budget. Budgets shrink as boards grow so a run
  // that exhausts its budget still finishes quickly; the unused upper bits of
  // the size write carry random values.
  task automatic pick_random_setting();
    logic [5:0]  raw_size;
    logic [15:0] budget;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      raw_size = 6'd0;
    end else if (pick < 10) begin
      raw_size = 6'($urandom_range(33, 63));
    end else if (pick < 20) begin
      raw_size = 6'($urandom_range(13, 32));
    end else if (pick < 35) begin
      raw_size = 6'($urandom_range(9, 12));
    end else begin
      raw_size = 6'($urandom_range(1, 8));
    end
    write_reg(nqls_pkg::REG_BOARD_SIZE, {10'($urandom), raw_size});
    n    = effective_size();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      budget = 16'd0;
    end else if (pick < 14) begin
      budget = 16'd1;
    end else if (pick < 20) begin
      budget = 16'd2;
    end else if (n <= 6) begin
      budget = (pick < 35) ? 16'hFFFF : 16'($urandom_range(3, 5000));
    end else if (n <= 8) begin
      budget = 16'($urandom_range(3, 3000));
    end else if (n <= 12) begin
      budget = 16'($urandom_range(3, 1000));
    end else begin
      budget = 16'($urandom_range(3, 300));
    end
    write_reg(nqls_pkg::REG_STEP_LIMIT, budget);
  endtask

  // Random boards under four idling mixes: none, sender idle, receiver
  // stalling, and both. Settings change between groups of boards.
  task automatic test_random_boards();
    int unsigned mix_start;
    for (int unsigned mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 58;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 58;
        end
        default: begin
          idle_pct  = 37;
          stall_pct = 37;
        end
      endcase
      mix_start = items_sent;
      while (items_sent - mix_start < RANDOM_ITEMS / 4) begin
        pick_random_setting();
        repeat ($urandom_range(1, 4)) send_board();
        drain_results();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_output_holdoff();
    test_largest_board();
    test_random_boards();
    drain_results();

    $display("Run covered %0d start rows in %0d searches (%0d solved) over %0d register writes,",
             items_sent, searches_run, searches_solved, settings_used);
    $display("with %0d column results checked under idle, stall and hold-off mixes.",
             results_checked);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
